/* src/ncr_pkg.sv */
// Shared types, character codes and the UTF-8 byte builder for the numeric
// character reference decoder. No dependencies.
`default_nettype none

package ncr_pkg;

  localparam logic [7:0]  CH_AMP   = 8'h26;
  localparam logic [7:0]  CH_HASH  = 8'h23;
  localparam logic [7:0]  CH_SEMI  = 8'h3B;
  localparam logic [7:0]  CH_X_LO  = 8'h78;
  localparam logic [7:0]  CH_X_UP  = 8'h58;
  localparam logic [7:0]  CH_0     = 8'h30;
  localparam logic [7:0]  CH_9     = 8'h39;
  localparam logic [7:0]  CH_A_LO  = 8'h61;
  localparam logic [7:0]  CH_F_LO  = 8'h66;
  localparam logic [7:0]  CH_A_UP  = 8'h41;
  localparam logic [7:0]  CH_F_UP  = 8'h46;

  localparam logic [20:0] CODE_LIMIT = 21'h10FFFF;
  localparam logic [20:0] ONE_MAX    = 21'h00007F;
  localparam logic [20:0] TWO_MAX    = 21'h0007FF;
  localparam logic [20:0] THREE_MAX  = 21'h00FFFF;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_AMP  = 3'd1,
    MODE_HASH = 3'd2,
    MODE_NUM  = 3'd3,
    MODE_SKIP = 3'd4
  } mode_t;

  // What follows the flushed raw bytes of one command.
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_BYTE = 2'd1,
    TAIL_CODE = 2'd2,
    TAIL_ERR  = 2'd3
  } tail_kind_t;

  typedef struct packed {
    tail_kind_t  kind;
    logic [20:0] code;     // code point, or the literal byte in the low bits
    logic [2:0]  len;      // number of tail results, 0 to 4
    logic        str_end;  // the item closed its string
  } tail_t;

  // Byte k (0 = lead) of the len-byte UTF-8 encoding of cp.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                           input logic [2:0]  len,
                                           input logic [2:0]  k);
    logic [2:0] j;
    logic [7:0] b;
    j = len - 3'd1 - k;
    b = 8'h00;
    if (k == 3'd0) begin
      case (len)
        3'd2:    b = {3'b110, cp[10:6]};
        3'd3:    b = {4'b1110, cp[15:12]};
        3'd4:    b = {5'b11110, cp[20:18]};
        default: b = cp[7:0];
      endcase
    end else begin
      case (j)
        3'd1:    b = {2'b10, cp[11:6]};
        3'd2:    b = {2'b10, cp[17:12]};
        default: b = {2'b10, cp[5:0]};
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/ncr_queue.sv */
// Small command queue between the parser front and the output back.
// Depends on nothing; width and depth are parameters.
`default_nettype none

module ncr_queue #(
  parameter int W     = 32,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              full,
  output logic              not_empty,
  output logic [W-1:0]      head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_data = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* src/ncr_front.sv */
// Parser front: accepts input bytes, tracks the open reference, holds its raw
// bytes and issues one command per item that produces results. Uses ncr_pkg.
`default_nettype none

module ncr_front #(
  parameter int ENTITY_MAX = 12
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_fire,
  input  wire logic [7:0]                             in_byte,
  input  wire logic                                   in_end,
  input  wire logic                                   flush_done,
  output logic                                        busy,
  output logic                                        cmd_push,
  output logic [$clog2(ENTITY_MAX+1)-1:0]             cmd_flush_n,
  output ncr_pkg::tail_t                              cmd_tail,
  output logic [7:0]                                  raw_buf [ENTITY_MAX]
);

  localparam int CW = $clog2(ENTITY_MAX + 1);
  localparam int IW = $clog2(ENTITY_MAX);

  ncr_pkg::mode_t mode_r, mode_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [20:0]    acc_r, acc_nxt;
  logic           hex_r, hex_nxt;
  logic           seen_r, seen_nxt;
  logic           ovf_r, ovf_nxt;
  logic           busy_r, busy_nxt;
  logic [7:0]     buf_r [ENTITY_MAX];

  logic           hold_en;
  logic [IW-1:0]  hold_idx;
  logic           do_flush, do_idle;
  logic           is_amp;
  logic           is_digit;
  logic [3:0]     dval;
  logic [24:0]    acc_mul;
  logic [24:0]    acc_sum;
  logic [2:0]     code_len;

  assign busy    = busy_r;
  assign raw_buf = buf_r;
  assign is_amp  = (in_byte == ncr_pkg::CH_AMP) && !in_end;

  // Digit value under the current radix.
  always_comb begin
    is_digit = 1'b0;
    dval     = 4'd0;
    if (in_byte >= ncr_pkg::CH_0 && in_byte <= ncr_pkg::CH_9) begin
      is_digit = 1'b1;
      dval     = 4'(in_byte - ncr_pkg::CH_0);
    end else if (hex_r && in_byte >= ncr_pkg::CH_A_LO && in_byte <= ncr_pkg::CH_F_LO) begin
      is_digit = 1'b1;
      dval     = 4'(in_byte - ncr_pkg::CH_A_LO + 8'd10);
    end else if (hex_r && in_byte >= ncr_pkg::CH_A_UP && in_byte <= ncr_pkg::CH_F_UP) begin
      is_digit = 1'b1;
      dval     = 4'(in_byte - ncr_pkg::CH_A_UP + 8'd10);
    end
  end

  assign acc_mul = hex_r ? {acc_r, 4'b0000}
                         : ({1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0});
  assign acc_sum = acc_mul + {21'd0, dval};

  always_comb begin
    if (acc_r <= ncr_pkg::ONE_MAX) begin
      code_len = 3'd1;
    end else if (acc_r <= ncr_pkg::TWO_MAX) begin
      code_len = 3'd2;
    end else if (acc_r <= ncr_pkg::THREE_MAX) begin
      code_len = 3'd3;
    end else begin
      code_len = 3'd4;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    acc_nxt     = acc_r;
    hex_nxt     = hex_r;
    seen_nxt    = seen_r;
    ovf_nxt     = ovf_r;
    hold_en     = 1'b0;
    hold_idx    = count_r[IW-1:0];
    do_flush    = 1'b0;
    do_idle     = 1'b0;
    cmd_push    = 1'b0;
    cmd_flush_n = '0;
    cmd_tail    = '0;
    cmd_tail.kind    = ncr_pkg::TAIL_NONE;
    cmd_tail.str_end = in_end;

    if (in_fire) begin
      case (mode_r)
        ncr_pkg::MODE_AMP: begin
          if (in_byte == ncr_pkg::CH_HASH && !in_end && count_r < CW'(ENTITY_MAX)) begin
            hold_en   = 1'b1;
            count_nxt = count_r + CW'(1);
            mode_nxt  = ncr_pkg::MODE_HASH;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        ncr_pkg::MODE_HASH, ncr_pkg::MODE_NUM, ncr_pkg::MODE_SKIP: begin
          if (in_byte == ncr_pkg::CH_SEMI) begin
            cmd_push = 1'b1;
            if (!seen_r || ovf_r) begin
              cmd_tail.kind = ncr_pkg::TAIL_ERR;
              cmd_tail.len  = 3'd1;
            end else begin
              cmd_tail.kind = ncr_pkg::TAIL_CODE;
              cmd_tail.code = acc_r;
              cmd_tail.len  = code_len;
            end
            mode_nxt  = ncr_pkg::MODE_IDLE;
            count_nxt = '0;
            acc_nxt   = '0;
            hex_nxt   = 1'b0;
            seen_nxt  = 1'b0;
            ovf_nxt   = 1'b0;
          end else if (in_end || count_r >= CW'(ENTITY_MAX)) begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end else begin
            hold_en   = 1'b1;
            count_nxt = count_r + CW'(1);
            if (mode_r == ncr_pkg::MODE_HASH &&
                (in_byte == ncr_pkg::CH_X_LO || in_byte == ncr_pkg::CH_X_UP)) begin
              hex_nxt  = 1'b1;
              mode_nxt = ncr_pkg::MODE_NUM;
            end else if (mode_r != ncr_pkg::MODE_SKIP) begin
              if (is_digit) begin
                seen_nxt = 1'b1;
                mode_nxt = ncr_pkg::MODE_NUM;
                if (!ovf_r) begin
                  if (acc_sum > {4'd0, ncr_pkg::CODE_LIMIT}) begin
                    ovf_nxt = 1'b1;
                  end else begin
                    acc_nxt = acc_sum[20:0];
                  end
                end
              end else begin
                mode_nxt = ncr_pkg::MODE_SKIP;
              end
            end
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_flush) begin
        cmd_push    = 1'b1;
        cmd_flush_n = count_r;
      end

      if (do_idle) begin
        acc_nxt  = '0;
        hex_nxt  = 1'b0;
        seen_nxt = 1'b0;
        ovf_nxt  = 1'b0;
        if (is_amp) begin
          // A new reference always starts with '&' in entry zero, so this write
          // leaves the byte that a flush still under way reads unchanged.
          hold_en   = 1'b1;
          hold_idx  = '0;
          count_nxt = CW'(1);
          mode_nxt  = ncr_pkg::MODE_AMP;
        end else begin
          cmd_push      = 1'b1;
          cmd_tail.kind = ncr_pkg::TAIL_BYTE;
          cmd_tail.code = {13'd0, in_byte};
          cmd_tail.len  = 3'd1;
          count_nxt     = '0;
          mode_nxt      = ncr_pkg::MODE_IDLE;
        end
      end
    end

    // Input stays blocked while held bytes are still being flushed.
    busy_nxt = busy_r;
    if (cmd_push && cmd_flush_n != '0) begin
      busy_nxt = 1'b1;
    end else if (flush_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ncr_pkg::MODE_IDLE;
      count_r <= '0;
      acc_r   <= '0;
      hex_r   <= 1'b0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
      hex_r   <= hex_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_en) begin
      buf_r[hold_idx] <= in_byte;
    end
  end

endmodule

`default_nettype wire

/* src/ncr_back.sv */
// Output back: walks the head command, sending held raw bytes and then the
// literal, error or UTF-8 bytes, into an output register. Uses ncr_pkg.
`default_nettype none

module ncr_back #(
  parameter int ENTITY_MAX = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cmd_valid,
  input  wire logic [$clog2(ENTITY_MAX+1)-1:0]   cmd_flush_n,
  input  wire ncr_pkg::tail_t                    cmd_tail,
  input  wire logic [7:0]                        raw_buf [ENTITY_MAX],
  output logic                                   cmd_pop,
  output logic                                   flush_done,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_byte,
  output logic                                   out_error,
  output logic                                   out_string_end,
  output logic                                   out_run_last
);

  localparam int CW = $clog2(ENTITY_MAX + 1);
  localparam int IW = $clog2(ENTITY_MAX);
  localparam int PW = CW + 1;

  logic [PW-1:0] pos_r, pos_nxt;
  logic          valid_r, valid_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          err_r, err_nxt;
  logic          send_end_r, send_end_nxt;
  logic          run_last_r, run_last_nxt;

  logic          emit;
  logic          last;
  logic [PW-1:0] total;
  logic [2:0]    k;

  assign emit  = cmd_valid && (!valid_r || out_ready);
  assign total = PW'(cmd_flush_n) + PW'(cmd_tail.len);
  assign last  = (pos_r == total - PW'(1));
  assign k     = 3'(pos_r - PW'(cmd_flush_n));

  assign cmd_pop    = emit && last;
  assign flush_done = emit && last && (cmd_flush_n != '0);

  always_comb begin
    byte_nxt     = byte_r;
    err_nxt      = err_r;
    send_end_nxt = send_end_r;
    run_last_nxt = run_last_r;
    pos_nxt      = pos_r;
    valid_nxt    = out_ready ? 1'b0 : valid_r;
    if (emit) begin
      valid_nxt    = 1'b1;
      err_nxt      = 1'b0;
      run_last_nxt = last;
      send_end_nxt = last && cmd_tail.str_end;
      pos_nxt      = last ? '0 : pos_r + PW'(1);
      if (pos_r < PW'(cmd_flush_n)) begin
        byte_nxt = raw_buf[pos_r[IW-1:0]];
      end else begin
        case (cmd_tail.kind)
          ncr_pkg::TAIL_ERR: begin
            byte_nxt = 8'h00;
            err_nxt  = 1'b1;
          end
          ncr_pkg::TAIL_CODE: begin
            byte_nxt = ncr_pkg::utf8_byte(cmd_tail.code, cmd_tail.len, k);
          end
          default: begin
            byte_nxt = cmd_tail.code[7:0];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    err_r      <= err_nxt;
    send_end_r <= send_end_nxt;
    run_last_r <= run_last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_error      = err_r;
  assign out_string_end = send_end_r;
  assign out_run_last   = run_last_r;

endmodule

`default_nettype wire

/* src/numeric_char_ref_to_utf8.sv */
// An item's first result passes through the command queue and then the output register.
// Throughput: plain bytes and references that close go one item per cycle at the input while
// the queue has room and no flush is under way; output sends results one by one (a code point
// gives 1 to 4, a flush its held count plus one, or the held count if its byte opens a new one).
// An item that flushes held bytes holds off input until the back has read them out of the buffer.
// Reset: synchronous, active-low rst_n clears parser, queue and output control; buffer not cleared.
// Top level: parser front, command queue and output back. Uses ncr_pkg and the three submodules.
`default_nettype none

module numeric_char_ref_to_utf8 #(
  parameter int ENTITY_MAX = 12
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_string_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [0] out_error, [1] out_run_last
  output logic            out_tlast   // out_string_end
);

  localparam int CW = $clog2(ENTITY_MAX + 1);
  localparam int QW = CW + $bits(ncr_pkg::tail_t);

  logic           in_fire;
  logic           busy;
  logic           cmd_push;
  logic [CW-1:0]  push_flush_n;
  ncr_pkg::tail_t push_tail;
  logic [7:0]     raw_buf [ENTITY_MAX];
  logic           q_full, q_valid, q_pop;
  logic [QW-1:0]  q_head;
  logic           flush_done;
  logic           out_error, out_run_last;

  assign in_tready = !busy && !q_full;
  assign in_fire   = in_tvalid && in_tready;

  ncr_front #(.ENTITY_MAX(ENTITY_MAX)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_byte     (in_tdata),
    .in_end      (in_tlast),
    .flush_done  (flush_done),
    .busy        (busy),
    .cmd_push    (cmd_push),
    .cmd_flush_n (push_flush_n),
    .cmd_tail    (push_tail),
    .raw_buf     (raw_buf)
  );

  ncr_queue #(.W(QW), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data ({push_flush_n, push_tail}),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_data (q_head)
  );

  ncr_back #(.ENTITY_MAX(ENTITY_MAX)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_valid),
    .cmd_flush_n    (q_head[QW-1 -: CW]),
    .cmd_tail       (ncr_pkg::tail_t'(q_head[$bits(ncr_pkg::tail_t)-1:0])),
    .raw_buf        (raw_buf),
    .cmd_pop        (q_pop),
    .flush_done     (flush_done),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_tdata),
    .out_error      (out_error),
    .out_string_end (out_tlast),
    .out_run_last   (out_run_last)
  );

  assign out_tuser = {out_run_last, out_error};

  // An error result is a single zero byte that ends its item's run.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_error |-> out_tdata == 8'h00 && out_run_last)
    else $error("error result is not a lone zero byte");

  // The end of a string can only fall on the last result of an item.
  a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_run_last)
    else $error("string end on a result that is not last of its item");

  // The front never offers a command to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !q_full)
    else $error("command pushed into a full queue");

endmodule

`default_nettype wire

/* verif/tb_numeric_char_ref_to_utf8.sv */
// Self-checking testbench for numeric_char_ref_to_utf8: drives text bytes with random gaps,
// predicts the decoded UTF-8 stream in SystemVerilog and compares every output item.
// Depends on ncr_pkg and the RTL top level only.
module tb_numeric_char_ref_to_utf8;

  localparam int ENT_MAX     = 12;
  localparam int TOTAL_ITEMS = 480;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       str_end;
    logic       run_last;
  } utf8_res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] want;
    logic       want_err;
  } dir_row_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  // Hand-typed expectation that travels with the item being offered.
  logic       row_typed    = 1'b0;
  logic [7:0] row_want     = 8'h00;
  logic       row_want_err = 1'b0;

  int sent_n      = 0;
  int accepted_n  = 0;
  int results_n   = 0;
  int err_marks_n = 0;
  int bad_n       = 0;
  int cycle_n     = 0;
  bit steady;

  assign steady = (sent_n >= 320) && (sent_n < 400);

  numeric_char_ref_to_utf8 #(.ENTITY_MAX(ENT_MAX)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    while (cycle_n < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_n++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------
  ncr_pkg::mode_t dec_mode = ncr_pkg::MODE_IDLE;
  logic [7:0]  held_bytes [ENT_MAX];
  int          held_n     = 0;
  logic [31:0] code_acc   = '0;
  bit          hex_mode   = 1'b0;
  bit          any_digit  = 1'b0;
  bit          over_limit = 1'b0;
  utf8_res_t   step_res [$];
  utf8_res_t   utf8_due [$];

  function automatic void put_res(input logic [7:0] d, input logic e);
    utf8_res_t r;
    r = '{data: d, err: e, str_end: 1'b0, run_last: 1'b0};
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void clear_ref();
    dec_mode   = ncr_pkg::MODE_IDLE;
    held_n     = 0;
    code_acc   = '0;
    hex_mode   = 1'b0;
    any_digit  = 1'b0;
    over_limit = 1'b0;
  endfunction

  function automatic void hold_byte(input logic [7:0] b);
    if (held_n < ENT_MAX) begin
      held_bytes[held_n] = b;
      held_n++;
    end
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) put_res(held_bytes[i], 1'b0);
    clear_ref();
  endfunction

  function automatic void text_byte(input logic [7:0] b, input logic last);
    if (b == ncr_pkg::CH_AMP && !last) begin
      clear_ref();
      dec_mode = ncr_pkg::MODE_AMP;
      hold_byte(b);
    end else begin
      put_res(b, 1'b0);
    end
  endfunction

  // 16 means the byte is not a digit in the current radix.
  function automatic int digit_of(input logic [7:0] b);
    if (b >= ncr_pkg::CH_0 && b <= ncr_pkg::CH_9) return int'(b - ncr_pkg::CH_0);
    if (hex_mode && b >= ncr_pkg::CH_A_LO && b <= ncr_pkg::CH_F_LO)
      return int'(b - ncr_pkg::CH_A_LO) + 10;
    if (hex_mode && b >= ncr_pkg::CH_A_UP && b <= ncr_pkg::CH_F_UP)
      return int'(b - ncr_pkg::CH_A_UP) + 10;
    return 16;
  endfunction

  function automatic void add_digit(input int d);
    logic [31:0] nxt;
    any_digit = 1'b1;
    if (!over_limit) begin
      nxt = code_acc * (hex_mode ? 32'd16 : 32'd10) + 32'(d);
      // Once past the limit the value is frozen and the reference is an error.
      if (nxt > 32'(ncr_pkg::CODE_LIMIT)) over_limit = 1'b1;
      else code_acc = nxt;
    end
  endfunction

  function automatic void close_ref();
    logic [31:0] cp;
    cp = code_acc;
    if (!any_digit || over_limit) begin
      put_res(8'h00, 1'b1);
    end else if (cp <= 32'(ncr_pkg::ONE_MAX)) begin
      put_res(cp[7:0], 1'b0);
    end else if (cp <= 32'(ncr_pkg::TWO_MAX)) begin
      put_res(8'hC0 | 8'(cp >> 6), 1'b0);
      put_res(8'h80 | 8'(cp & 32'h3F), 1'b0);
    end else if (cp <= 32'(ncr_pkg::THREE_MAX)) begin
      put_res(8'hE0 | 8'(cp >> 12), 1'b0);
      put_res(8'h80 | 8'((cp >> 6) & 32'h3F), 1'b0);
      put_res(8'h80 | 8'(cp & 32'h3F), 1'b0);
    end else begin
      put_res(8'hF0 | 8'(cp >> 18), 1'b0);
      put_res(8'h80 | 8'((cp >> 12) & 32'h3F), 1'b0);
      put_res(8'h80 | 8'((cp >> 6) & 32'h3F), 1'b0);
      put_res(8'h80 | 8'(cp & 32'h3F), 1'b0);
    end
    clear_ref();
  endfunction

  function automatic void decode_step(input logic [7:0] b, input logic last);
    int        d;
    utf8_res_t tail;
    step_res.delete();
    if (dec_mode == ncr_pkg::MODE_IDLE) begin
      text_byte(b, last);
    end else if (dec_mode == ncr_pkg::MODE_AMP) begin
      if (b == ncr_pkg::CH_HASH && !last && held_n < ENT_MAX) begin
        hold_byte(b);
        dec_mode = ncr_pkg::MODE_HASH;
      end else begin
        flush_held();
        text_byte(b, last);
      end
    end else if (b == ncr_pkg::CH_SEMI) begin
      close_ref();
    end else if (last || held_n >= ENT_MAX) begin
      flush_held();
      text_byte(b, last);
    end else begin
      hold_byte(b);
      if (dec_mode == ncr_pkg::MODE_HASH && (b == ncr_pkg::CH_X_LO || b == ncr_pkg::CH_X_UP)) begin
        hex_mode = 1'b1;
        dec_mode = ncr_pkg::MODE_NUM;
      end else if (dec_mode == ncr_pkg::MODE_HASH || dec_mode == ncr_pkg::MODE_NUM) begin
        d = digit_of(b);
        if (d < 16) begin
          add_digit(d);
          dec_mode = ncr_pkg::MODE_NUM;
        end else begin
          dec_mode = ncr_pkg::MODE_SKIP;
        end
      end
    end
    if (step_res.size() > 0) begin
      tail          = step_res.pop_back();
      tail.str_end  = last;
      tail.run_last = 1'b1;
      step_res.insert(step_res.size(), tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: outputs are checked before the accepted input is predicted,
  // which is safe since no item can produce a result in its own cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    utf8_res_t want;
    utf8_res_t typed_res;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_n++;
        if (out_tuser[0]) err_marks_n++;
        if (utf8_due.size() == 0) begin
          bad_n++;
          $display("%0t: unexpected output item: data %02h error %b run_last %b last %b",
                   $time, out_tdata, out_tuser[0], out_tuser[1], out_tlast);
        end else begin
          want = utf8_due.pop_front();
          if (out_tdata !== want.data) begin
            bad_n++;
            $display("%0t: out_tdata expected %02h got %02h", $time, want.data, out_tdata);
          end
          if (out_tuser[0] !== want.err) begin
            bad_n++;
            $display("%0t: error flag expected %b got %b", $time, want.err, out_tuser[0]);
          end
          if (out_tuser[1] !== want.run_last) begin
            bad_n++;
            $display("%0t: run_last expected %b got %b", $time, want.run_last, out_tuser[1]);
          end
          if (out_tlast !== want.str_end) begin
            bad_n++;
            $display("%0t: out_tlast expected %b got %b", $time, want.str_end, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        accepted_n++;
        decode_step(in_tdata, in_tlast);
        if (row_typed) begin
          typed_res = '{data: row_want, err: row_want_err, str_end: in_tlast,
                        run_last: 1'b1};
          utf8_due.insert(utf8_due.size(), typed_res);
        end else begin
          foreach (step_res[i]) utf8_due.insert(utf8_due.size(), step_res[i]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure plus one long hold-off.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    bit hold_done;
    int hold_cycles;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!hold_done && sent_n >= 200) begin
        out_tready  <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_done = 1'b1;
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  logic [8:0] seg [$];  // {last, byte}

  function automatic void seg_add(input logic [8:0] e);
    seg.insert(seg.size(), e);
  endfunction

  task automatic send(input logic [7:0] b, input logic last, input logic typed,
                      input logic [7:0] want, input logic want_err);
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= b;
    in_tlast     <= last;
    row_typed    <= typed;
    row_want     <= want;
    row_want_err <= want_err;
    do @(posedge clk); while (!in_tready);
    sent_n++;
  endtask

  // Appends one reference, closed by a semicolon, with a random code point, radix and spelling.
  task automatic build_ref();
    logic [31:0] cp;
    logic [7:0]  digs [$];
    logic [7:0]  junk;
    bit          hexr;
    int          pick;
    int          d;
    pick = $urandom_range(0, 9);
    hexr = $urandom_range(0, 1);
    case (pick)
      0, 1:    cp = $urandom_range(0, 'h7F);
      2:       cp = $urandom_range('h80, 'h7FF);
      3:       cp = $urandom_range('h800, 'hFFFF);
      4:       cp = $urandom_range('hD800, 'hDFFF);
      5, 6:    cp = $urandom_range('h10000, 'h10FFFF);
      7: begin
        case ($urandom_range(0, 8))
          0:       cp = 32'h0;
          1:       cp = 32'h7F;
          2:       cp = 32'h80;
          3:       cp = 32'h7FF;
          4:       cp = 32'h800;
          5:       cp = 32'hFFFF;
          6:       cp = 32'h10000;
          7:       cp = 32'h10FFFF;
          default: cp = 32'h110000;
        endcase
      end
      8:       cp = $urandom_range('h110000, 'hFFFFFF);
      default: cp = 32'h0;
    endcase
    seg_add({1'b0, ncr_pkg::CH_AMP});
    seg_add({1'b0, ncr_pkg::CH_HASH});
    if (hexr) seg_add({1'b0, ($urandom_range(0, 1) ? ncr_pkg::CH_X_LO : ncr_pkg::CH_X_UP)});
    // The last pick leaves the reference without any digits.
    if (pick != 9) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) seg_add({1'b0, ncr_pkg::CH_0});
      do begin
        d  = hexr ? int'(cp % 16) : int'(cp % 10);
        cp = hexr ? cp / 16 : cp / 10;
        if (d < 10) digs.push_front(ncr_pkg::CH_0 + 8'(d));
        else digs.push_front(($urandom_range(0, 1) ? ncr_pkg::CH_A_LO : ncr_pkg::CH_A_UP)
                             + 8'(d - 10));
      end while (cp != 0);
      foreach (digs[i]) seg_add({1'b0, digs[i]});
    end
    // Random trailing bytes, never a semicolon, may follow the digits; those that are not digits are dropped.
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        junk = 8'($urandom);
        if (junk == ncr_pkg::CH_SEMI) junk = ncr_pkg::CH_A_LO;
        seg_add({1'b0, junk});
      end
    end
    seg_add({1'b0, ncr_pkg::CH_SEMI});
  endtask

  initial begin : sender
    dir_row_t   dir_tab [26];
    logic [8:0] tail;
    int         kind;
    int         k;
    bit         pause_done;
    pause_done = 1'b0;
    dir_tab = '{
      '{8'h00,            1'b0, 1'b1, 8'h00,           1'b0},
      '{8'hFF,            1'b1, 1'b1, 8'hFF,           1'b0},
      // Reference with no digits.
      '{ncr_pkg::CH_AMP,  1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_HASH, 1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_SEMI, 1'b0, 1'b1, 8'h00,           1'b1},
      // Ampersand that ends its string goes out as text.
      '{ncr_pkg::CH_AMP,  1'b1, 1'b1, ncr_pkg::CH_AMP, 1'b0},
      // Ampersand not followed by a hash.
      '{ncr_pkg::CH_AMP,  1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_A_LO, 1'b0, 1'b0, 8'h00,           1'b0},
      // Surrogate code point D800 in hex.
      '{ncr_pkg::CH_AMP,  1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_HASH, 1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_X_LO, 1'b0, 1'b0, 8'h00,           1'b0},
      '{8'h44,            1'b0, 1'b0, 8'h00,           1'b0},
      '{8'h38,            1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_0,    1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_0,    1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_SEMI, 1'b0, 1'b0, 8'h00,           1'b0},
      // First value past the code point limit.
      '{ncr_pkg::CH_AMP,  1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_HASH, 1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_X_UP, 1'b0, 1'b0, 8'h00,           1'b0},
      '{8'h31,            1'b0, 1'b0, 8'h00,           1'b0},
      '{8'h31,            1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_0,    1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_0,    1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_0,    1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_0,    1'b0, 1'b0, 8'h00,           1'b0},
      '{ncr_pkg::CH_SEMI, 1'b1, 1'b1, 8'h00,           1'b1}
    };
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    foreach (dir_tab[i])
      send(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want,
           dir_tab[i].want_err);

    while (sent_n < TOTAL_ITEMS) begin
      if (!pause_done && sent_n >= 130) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (utf8_due.size() != 0);
        pause_done = 1'b1;
      end
      seg.delete();
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        repeat ($urandom_range(1, 4))
          seg_add({1'($urandom_range(0, 7) == 0), 8'($urandom)});
      end else if (kind < 75) begin
        build_ref();
        if ($urandom_range(0, 3) == 0) begin
          tail = seg.pop_back();
          seg_add({1'b1, tail[7:0]});
        end
      end else if (kind < 87) begin
        // Reference cut short, either by the end of its string or by what follows.
        build_ref();
        k = $urandom_range(1, seg.size() - 2);
        while (seg.size() > k + 1) void'(seg.pop_back());
        if ($urandom_range(0, 1) == 1) begin
          tail = seg.pop_back();
          seg_add({1'b1, tail[7:0]});
        end
      end else if (kind < 94) begin
        seg_add({1'b0, ncr_pkg::CH_AMP});
        seg_add({1'($urandom_range(0, 3) == 0), 8'($urandom)});
      end else begin
        // More bytes than the reference buffer holds.
        seg_add({1'b0, ncr_pkg::CH_AMP});
        seg_add({1'b0, ncr_pkg::CH_HASH});
        repeat ($urandom_range(11, 14))
          seg_add({1'b0, ncr_pkg::CH_0 + 8'($urandom_range(0, 9))});
        if ($urandom_range(0, 1) == 1) seg_add({1'b0, ncr_pkg::CH_SEMI});
      end
      foreach (seg[i]) send(seg[i][7:0], seg[i][8], 1'b0, 8'h00, 1'b0);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (utf8_due.size() != 0);
    repeat (20) @(posedge clk);

    $display("Decoded %0d input bytes into %0d checked output bytes (%0d error markers),",
             accepted_n, results_n, err_marks_n);
    $display("covering plain text, decimal and hex references, flushes and back-pressure.");
    if (bad_n == 0 && utf8_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* numeric_char_ref_to_utf8.f */
src/ncr_pkg.sv
src/ncr_queue.sv
src/ncr_front.sv
src/ncr_back.sv
src/numeric_char_ref_to_utf8.sv
verif/tb_numeric_char_ref_to_utf8.sv
